// ----- src/mcw_pkg.sv -----
`default_nettype none

package mcw_pkg;

  // field widths
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned DbW      = 15;
  localparam int unsigned CmdW     = 16;
  localparam int unsigned SpeedW   = 15;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  typedef logic [1:0]        dir_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // direction codes
  localparam dir_t DIR_BRAKE = 2'd0;
  localparam dir_t DIR_CW    = 2'd1;
  localparam dir_t DIR_CCW   = 2'd2;

  // register indexes
  localparam cfg_idx_t REG_TIMEOUT   = 2'd0;
  localparam cfg_idx_t REG_DEADBAND  = 2'd1;
  localparam cfg_idx_t REG_DRIVE_MAX = 2'd2;

  // item kinds carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  // message type bytes and lengths
  localparam logic [ByteW-1:0] TYPE_DRIVE = 8'h63;
  localparam logic [ByteW-1:0] TYPE_SWEEP = 8'h73;
  localparam logic [ByteW-1:0] LEN_DRIVE  = 8'd6;
  localparam logic [ByteW-1:0] LEN_SWEEP  = 8'd3;

  localparam logic [ElapsedW-1:0] ELAPSED_MAX = {ElapsedW{1'b1}};

  localparam logic [TimeoutW-1:0] TIMEOUT_RST   = 16'd500;
  localparam logic [DbW-1:0]      DEADBAND_RST  = 15'd5;
  localparam logic [DbW-1:0]      DRIVE_MAX_RST = 15'd255;

  typedef struct packed {
    dir_t              dir;
    logic [SpeedW-1:0] speed;
  } motor_drv_t;

  // sign-extend a 16-bit command and clamp it to +/- lim
  function automatic logic signed [CmdW-1:0] clamp_cmd(
    input logic [ByteW-1:0] hi,
    input logic [ByteW-1:0] lo,
    input logic [DbW-1:0]   lim
  );
    logic signed [CmdW:0] v;
    logic signed [CmdW:0] l;
    logic signed [CmdW:0] r;
    v = {hi[ByteW-1], hi, lo};
    l = {2'b00, lim};
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[CmdW-1:0];
  endfunction

  // deadband and direction for one motor
  function automatic motor_drv_t motor_drive(
    input logic signed [CmdW-1:0] cmd,
    input logic [DbW-1:0]         db,
    input dir_t                   fwd,
    input dir_t                   back
  );
    logic signed [CmdW:0] c;
    logic signed [CmdW:0] d;
    logic signed [CmdW:0] neg;
    motor_drv_t           r;
    c   = {cmd[CmdW-1], cmd};
    d   = {2'b00, db};
    neg = -c;
    if (c < -d) begin
      r.dir   = back;
      r.speed = neg[SpeedW-1:0];
    end else if (c > d) begin
      r.dir   = fwd;
      r.speed = c[SpeedW-1:0];
    end else begin
      r.dir   = DIR_BRAKE;
      r.speed = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/motor_command_watchdog.sv -----
`default_nettype none

// channel  | dir | handshake         | payload
// ---------+-----+-------------------+----------------------------------------------
// in       | in  | in_tvalid/tready  | tuser: opcode; tdata: len, byte0..byte5
// out      | out | out_tvalid/tready | tdata: l_dir, l_speed, r_dir, r_speed, sweep
// cfg      | in  | cfg_valid/ready   | cfg_index, cfg_data (always ready)
//
// one beat per cycle while no tick is held back by a stalled result: a beat lands
// in the input register, and from there the state update and the motor outputs are
// formed in one pass into the result register.
// reset (rst_n low, synchronous) empties both registers and loads the register
// defaults and the command state. a stalled result holds only tick beats back;
// message beats pass through the input register even while a result waits.

module motor_command_watchdog (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input beats
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [7:0] msg_len, [15:8] msg_byte0 ... [55:48] msg_byte5
  input  wire logic [mcw_pkg::InDataW-1:0]   in_tdata,
  // [0] opcode
  input  wire logic                          in_tuser,
  // result beats
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [1:0] left_dir, [16:2] left_speed, [18:17] right_dir, [33:19] right_speed,
  // [41:34] sweep_cmd, [47:42] zero
  output logic [mcw_pkg::OutDataW-1:0]       out_tdata,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mcw_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [mcw_pkg::TimeoutW-1:0]  cfg_data
);
  import mcw_pkg::*;

  // configuration registers
  logic [TimeoutW-1:0] timeout_r;
  logic [DbW-1:0]      deadband_r;
  logic [DbW-1:0]      drive_max_r;

  // input register
  logic                in_vld_r;
  logic                in_op_r;
  logic [InDataW-1:0]  in_data_r;

  // command state
  logic                   enabled_r, enabled_nxt;
  logic signed [CmdW-1:0] left_cmd_r, left_cmd_nxt;
  logic signed [CmdW-1:0] right_cmd_r, right_cmd_nxt;
  logic [ByteW-1:0]       sweep_r, sweep_nxt;
  logic [ElapsedW-1:0]    elapsed_r, elapsed_nxt;

  // result register
  logic                out_vld_r, out_vld_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  logic [ByteW-1:0] m_len, m_b0, m_b1, m_b2, m_b3, m_b4, m_b5;
  logic             is_msg, drive_ok, sweep_ok, proc_fire, emit;
  logic             timed_out;
  logic signed [CmdW-1:0] left_eff, right_eff;
  logic [ByteW-1:0]       sweep_eff;
  motor_drv_t       left_drv, right_drv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      deadband_r  <= DEADBAND_RST;
      drive_max_r <= DRIVE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMEOUT:   timeout_r   <= cfg_data;
        REG_DEADBAND:  deadband_r  <= cfg_data[DbW-1:0];
        REG_DRIVE_MAX: drive_max_r <= cfg_data[DbW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // unpack the held beat
  assign m_len = in_data_r[7:0];
  assign m_b0  = in_data_r[15:8];
  assign m_b1  = in_data_r[23:16];
  assign m_b2  = in_data_r[31:24];
  assign m_b3  = in_data_r[39:32];
  assign m_b4  = in_data_r[47:40];
  assign m_b5  = in_data_r[55:48];

  assign is_msg   = (in_op_r == OP_MSG);
  assign drive_ok = (m_b0 == TYPE_DRIVE) && (m_len == LEN_DRIVE);
  assign sweep_ok = (m_b0 == TYPE_SWEEP) && (m_len == LEN_SWEEP);

  // messages never need the result register; ticks wait for room there
  assign proc_fire = in_vld_r && (is_msg || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_data_r <= in_tdata;
    end
  end

  // watchdog: saturating count, compared after the increment
  always_comb begin
    elapsed_nxt = elapsed_r;
    if (elapsed_r != ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
  end
  assign timed_out = (elapsed_nxt > {1'b0, timeout_r});

  assign left_eff  = timed_out ? '0 : left_cmd_r;
  assign right_eff = timed_out ? '0 : right_cmd_r;
  assign sweep_eff = timed_out ? '0 : sweep_r;

  // forward is cw on the left motor, ccw on the right
  assign left_drv  = motor_drive(left_eff, deadband_r, DIR_CW, DIR_CCW);
  assign right_drv = motor_drive(right_eff, deadband_r, DIR_CCW, DIR_CW);

  assign emit = proc_fire && !is_msg && enabled_r;

  logic [ElapsedW-1:0] elapsed_upd;

  always_comb begin
    enabled_nxt   = enabled_r;
    left_cmd_nxt  = left_cmd_r;
    right_cmd_nxt = right_cmd_r;
    sweep_nxt     = sweep_r;
    elapsed_upd   = elapsed_r;
    if (proc_fire) begin
      if (is_msg) begin
        if (drive_ok) begin
          elapsed_upd   = '0;
          enabled_nxt   = (m_b1 != '0);
          left_cmd_nxt  = clamp_cmd(m_b2, m_b3, drive_max_r);
          right_cmd_nxt = clamp_cmd(m_b4, m_b5, drive_max_r);
        end else if (sweep_ok) begin
          elapsed_upd = '0;
          enabled_nxt = (m_b1 != '0);
          sweep_nxt   = m_b2;
        end
      end else begin
        elapsed_upd   = elapsed_nxt;
        left_cmd_nxt  = left_eff;
        right_cmd_nxt = right_eff;
        sweep_nxt     = sweep_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      left_cmd_r  <= '0;
      right_cmd_r <= '0;
      sweep_r     <= '0;
      elapsed_r   <= '0;
    end else begin
      enabled_r   <= enabled_nxt;
      left_cmd_r  <= left_cmd_nxt;
      right_cmd_r <= right_cmd_nxt;
      sweep_r     <= sweep_nxt;
      elapsed_r   <= elapsed_upd;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (emit) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = {6'b0, sweep_eff, right_drv.speed, right_drv.dir,
                      left_drv.speed, left_drv.dir};
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // a valid message restarts the watchdog
  a_msg_clears_wd: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && is_msg && (drive_ok || sweep_ok) |=> elapsed_r == '0)
    else $error("watchdog not cleared by valid message");

  // an enabled tick always leaves a result behind
  a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && !is_msg && enabled_r |=> out_vld_r)
    else $error("enabled tick lost its result");

  // a braked left motor carries no speed
  a_brake_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r[1:0] == DIR_BRAKE |-> out_data_r[16:2] == '0)
    else $error("braked left motor with nonzero speed");

  // a tick is never taken while a result is held back
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !emit)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
